// File: rtl/tpc_pkg.sv
package tpc_pkg;

  localparam int unsigned QDEPTH = 4;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic [1:0] BV_NONE = 2'd0;
  localparam logic [1:0] BV_ONE  = 2'd1;

  localparam logic [31:0] IPV4_HDR_BYTES = 32'd20;
  localparam logic [31:0] IPV6_HDR_BYTES = 32'd40;
  localparam logic [31:0] IPV4_ADDR_LO   = 32'd12;
  localparam logic [31:0] IPV6_ADDR_LO   = 32'd8;

  localparam logic [15:0] FAIL_CSUM = 16'd1;

  typedef struct packed {
    logic        first;
    logic        last;
    logic        fail;
    logic [15:0] word;
    logic [15:0] len_hi;
    logic [15:0] len_lo;
    logic [7:0]  proto;
  } tpc_entry_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // four-term ones' complement sum, folded twice
  function automatic logic [15:0] oc_sum4(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c, input logic [15:0] d);
    logic [17:0] t;
    logic [16:0] u;
    t = {2'd0, a} + {2'd0, b} + {2'd0, c} + {2'd0, d};
    u = {1'b0, t[15:0]} + {15'd0, t[17:16]};
    return u[15:0] + {15'd0, u[16]};
  endfunction

endpackage

// File: rtl/tpc_front.sv
module tpc_front #(
  parameter int unsigned POSITION_WIDTH = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [15:0]             in_data_word,
  input  logic [1:0]              in_bytes_valid,
  input  logic                    in_first_word,
  input  logic                    in_last_word,
  input  logic [1:0]              in_net_family,
  input  logic [7:0]              in_transport_protocol,
  input  logic                    q_full,
  output logic                    push,
  output tpc_pkg::tpc_entry_t     push_entry
);

  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt, pos_cur;
  logic [1:0]                fam_r, fam_cur;
  logic [7:0]                proto_r, proto_cur;
  logic [1:0]                nb;
  logic [15:0]               word_m;
  logic [POSITION_WIDTH:0]   pos_sum;
  logic [31:0]               pos32_cur, pos32_nxt, v4_len, v6_len;
  logic                      known, in_addr;

  assign push = in_valid && !q_full;

  always_comb begin
    pos_cur   = in_first_word ? '0 : pos_r;
    fam_cur   = in_first_word ? in_net_family : fam_r;
    proto_cur = in_first_word ? in_transport_protocol : proto_r;

    case (in_bytes_valid)
      tpc_pkg::BV_NONE: nb = 2'd0;
      tpc_pkg::BV_ONE:  nb = 2'd1;
      default:          nb = 2'd2;
    endcase
    word_m = (nb == 2'd1) ? {in_data_word[15:8], 8'h00} : in_data_word;

    pos32_cur = 32'(pos_cur);
    known     = (fam_cur == tpc_pkg::FAM_IPV4) || (fam_cur == tpc_pkg::FAM_IPV6);
    in_addr   = (fam_cur == tpc_pkg::FAM_IPV4) ? (pos32_cur >= tpc_pkg::IPV4_ADDR_LO)
                                               : (pos32_cur >= tpc_pkg::IPV6_ADDR_LO);

    pos_sum = {1'b0, pos_cur} + (POSITION_WIDTH+1)'(nb);
    pos_nxt = pos_sum[POSITION_WIDTH] ? '1 : pos_sum[POSITION_WIDTH-1:0];

    pos32_nxt = 32'(pos_nxt);
    v4_len    = pos32_nxt - tpc_pkg::IPV4_HDR_BYTES;
    v6_len    = (pos32_nxt >= tpc_pkg::IPV6_HDR_BYTES) ?
                (pos32_nxt - tpc_pkg::IPV6_HDR_BYTES) : 32'd0;

    push_entry.first = in_first_word;
    push_entry.last  = in_last_word;
    push_entry.word  = (known && nb != 2'd0 && in_addr) ? word_m : 16'd0;
    push_entry.proto = proto_cur;
    case (fam_cur)
      tpc_pkg::FAM_IPV4: begin
        push_entry.fail   = (pos32_nxt < tpc_pkg::IPV4_HDR_BYTES);
        push_entry.len_hi = 16'd0;
        push_entry.len_lo = v4_len[15:0];
      end
      tpc_pkg::FAM_IPV6: begin
        push_entry.fail   = 1'b0;
        push_entry.len_hi = v6_len[31:16];
        push_entry.len_lo = v6_len[15:0];
      end
      default: begin
        push_entry.fail   = 1'b1;
        push_entry.len_hi = 16'd0;
        push_entry.len_lo = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fam_r   <= tpc_pkg::FAM_IPV4;
      proto_r <= 8'd0;
    end else if (push) begin
      fam_r   <= fam_cur;
      proto_r <= proto_cur;
      pos_r   <= in_last_word ? '0 : pos_nxt;
    end
  end

endmodule

// File: rtl/tpc_fifo.sv
module tpc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tpc_pkg::tpc_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output tpc_pkg::tpc_entry_t head
);

  localparam int unsigned AW = $clog2(tpc_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(tpc_pkg::QDEPTH + 1);

  tpc_pkg::tpc_entry_t mem_r [tpc_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(tpc_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(tpc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(tpc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(tpc_pkg::QDEPTH))
    else $error("queue count past depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

endmodule

// File: rtl/tpc_back.sv
module tpc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  tpc_pkg::tpc_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_checksum,
  output logic                out_failed
);

  logic [15:0] sum_r, sum_nxt;
  logic        fin_valid_r;
  logic [15:0] fin_sum_r, fin_len_hi_r, fin_len_lo_r;
  logic [7:0]  fin_proto_r;
  logic        fin_fail_r;
  logic        out_valid_r;
  logic [15:0] out_checksum_r;
  logic        out_failed_r;
  logic        out_free, fin_free, fin_move;
  logic [15:0] fin_total;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_move = fin_valid_r && out_free;
  assign fin_free = !fin_valid_r || out_free;
  assign pop      = !empty && (!head.last || fin_free);
  assign sum_nxt  = tpc_pkg::oc_add(head.first ? 16'd0 : sum_r, head.word);
  assign fin_total = tpc_pkg::oc_sum4(fin_sum_r, fin_len_hi_r, fin_len_lo_r,
                                      {8'd0, fin_proto_r});

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;
  assign out_failed   = out_failed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= 16'd0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        sum_r <= head.last ? 16'd0 : sum_nxt;
      end
      if (pop && head.last) begin
        fin_valid_r <= 1'b1;
      end else if (fin_move) begin
        fin_valid_r <= 1'b0;
      end
      if (fin_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      fin_sum_r    <= sum_nxt;
      fin_len_hi_r <= head.len_hi;
      fin_len_lo_r <= head.len_lo;
      fin_proto_r  <= head.proto;
      fin_fail_r   <= head.fail;
    end
    if (fin_move) begin
      out_checksum_r <= fin_fail_r ? tpc_pkg::FAIL_CSUM : ~fin_total;
      out_failed_r   <= fin_fail_r;
    end
  end

  a_last_reaches_fin: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.last |=> fin_valid_r)
    else $error("last request dropped before final stage");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid_r && !out_free |=> fin_valid_r && $stable(fin_sum_r))
    else $error("final stage lost its sum while output busy");

endmodule

// File: rtl/transport_pseudo_header_checksum.sv
// Transport pseudo-header checksum for TCP/UDP over IPv4 or IPv6. Packet words
// (big-endian 16-bit) are taken one per clock while in_stall is low; a result
// is given once per packet for the word flagged last. The front end tracks the
// byte position and family, marks address and payload words and works out the
// payload length; a four-entry queue then feeds the back end, whose 16-bit
// end-around adder sets the sustained rate by folding one word per cycle
// unless a last word waits for a busy final stage. A result passes from the
// queue through the final stage register to the output register, where
// out_stall holds it while the block keeps taking words until the queue fills.
module transport_pseudo_header_checksum #(
  parameter int unsigned POSITION_WIDTH = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_data_word,
  input  logic [1:0]  in_bytes_valid,
  input  logic        in_first_word,
  input  logic        in_last_word,
  input  logic [1:0]  in_net_family,
  input  logic [7:0]  in_transport_protocol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic        out_failed
);

  tpc_pkg::tpc_entry_t push_entry, head;
  logic push, pop, full, empty;

  assign in_stall = full;

  tpc_front #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_data_word          (in_data_word),
    .in_bytes_valid        (in_bytes_valid),
    .in_first_word         (in_first_word),
    .in_last_word          (in_last_word),
    .in_net_family         (in_net_family),
    .in_transport_protocol (in_transport_protocol),
    .q_full                (full),
    .push                  (push),
    .push_entry            (push_entry)
  );

  tpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  tpc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum),
    .out_failed   (out_failed)
  );

endmodule
